// File: sv/ir_text_tokenizer_macros.svh
// assertion helpers for the tokenizer, clocked on clk and disabled in rst
`ifndef IR_TEXT_TOKENIZER_MACROS_SVH
`define IR_TEXT_TOKENIZER_MACROS_SVH

// consequent checked in the same cycle
`define IRTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define IRTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/irtt_pkg.sv
`timescale 1ns / 1ps

package irtt_pkg;

  localparam int LINE_WIDTH_DEF = 24;
  localparam int LINE_NO_W = 24;
  localparam int HOLD = 2;                       // lookahead bytes kept between transfers
  localparam int WIN = HOLD + 2;                 // held bytes, new byte, closing newline
  localparam int WIN_W = $clog2(WIN + 1);
  localparam int MAX_RES = WIN + 1;              // one per window byte plus an error
  localparam int CNT_W = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_US     = 8'h5f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7a;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5a;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_QUOTE = 2'd1,
    ERR_IDENT = 2'd2
  } err_t;

  typedef enum logic [7:0] {
    M_BETWEEN = 8'b0000_0001,
    M_SIGIL   = 8'b0000_0010,
    M_IDC     = 8'b0000_0100,
    M_IDN     = 8'b0000_1000,
    M_COLON   = 8'b0001_0000,
    M_QUOTEC  = 8'b0010_0000,
    M_QUOTEN  = 8'b0100_0000,
    M_COMMENT = 8'b1000_0000
  } lex_mode_t;

  typedef struct packed {
    logic [7:0]           ch;
    logic                 first;
    logic                 last;
    logic [LINE_NO_W-1:0] line;
    err_t                 err;
    logic                 done;
    logic                 run_last;
  } res_t;

  // outcome of lexing at one window position
  typedef struct packed {
    logic            stop;
    logic            sig_err;
    logic [1:0]      adv;
    logic [1:0]      n;
    logic            nl;
    lex_mode_t       mode;
    logic [2:0][7:0] ch;
    logic [2:0]      first;
    logic [2:0]      last;
  } lex_step_t;

  function automatic logic is_ident(input logic [7:0] c);
    is_ident = c inside {[CH_D0:CH_D9], [CH_LA:CH_LZ], [CH_UA:CH_UZ],
                         CH_DOLLAR, CH_MINUS, CH_DOT, CH_US};
  endfunction

  function automatic lex_step_t lex_step(input lex_mode_t mode, input logic [7:0] f,
                                         input logic have1, input logic [7:0] nb,
                                         input logic have2, input logic [7:0] nb2,
                                         input logic end_in);
    lex_step_t r;
    lex_mode_t m;
    logic stall;
    logic id_byte;
    logic id_first;
    logic colon_ok;
    logic cont;
    logic col;
    r = '0;
    stall = !have1 && !end_in;
    id_byte = 1'b0;
    id_first = 1'b0;
    colon_ok = 1'b0;
    cont = 1'b0;
    col = 1'b0;
    m = mode;
    // a sigil followed by an identifier byte, or a comment closed by newline
    if (mode == M_SIGIL && is_ident(f)) m = M_IDN;
    if (mode == M_COMMENT && f == CH_NL) m = M_BETWEEN;
    r.mode = m;
    r.adv = 2'd1;
    r.ch = {3{f}};
    case (m)
      M_BETWEEN: begin
        if (f == CH_DOT && !have2 && !end_in) begin
          r.stop = 1'b1;
        end else if (f == CH_DOT && have2 && nb == CH_DOT && nb2 == CH_DOT) begin
          r.n = 2'd3;
          r.adv = 2'd3;
          r.first = 3'b001;
          r.last = 3'b100;
        end else if (f inside {CH_SP, CH_FF, CH_CR, CH_TAB}) begin
          r.n = 2'd0;
        end else if (f == CH_QUOTE) begin
          r.n = 2'd1;
          r.first = 3'b001;
          r.mode = M_QUOTEC;
        end else if (f inside {CH_DOLLAR, CH_PCT, CH_AT}) begin
          r.n = 2'd1;
          r.first = 3'b001;
          r.mode = M_SIGIL;
        end else if (f == CH_SEMI) begin
          r.mode = M_COMMENT;
        end else if (f == CH_NL) begin
          r.n = 2'd1;
          r.first = 3'b001;
          r.last = 3'b001;
          r.nl = 1'b1;
        end else if (f == CH_C && stall) begin
          r.stop = 1'b1;
        end else if (f == CH_C && nb == CH_QUOTE) begin
          r.n = 2'd2;
          r.adv = 2'd2;
          r.ch[1] = CH_QUOTE;
          r.first = 3'b001;
          r.mode = M_QUOTEN;
        end else if (is_ident(f)) begin
          id_byte = 1'b1;
          id_first = 1'b1;
          colon_ok = 1'b1;
        end else begin
          r.n = 2'd1;
          r.first = 3'b001;
          r.last = 3'b001;
        end
      end
      M_SIGIL: begin
        if (f == CH_QUOTE) begin
          r.n = 2'd1;
          r.mode = M_QUOTEN;
        end else begin
          r.sig_err = 1'b1;
          r.adv = 2'd0;
        end
      end
      M_IDC: begin
        id_byte = 1'b1;
        colon_ok = 1'b1;
      end
      M_IDN: begin
        id_byte = 1'b1;
      end
      M_COLON: begin
        r.n = 2'd1;
        r.last = 3'b001;
        r.mode = M_BETWEEN;
      end
      M_QUOTEC: begin
        if (f == CH_QUOTE) begin
          if (stall) begin
            r.stop = 1'b1;
          end else if (nb == CH_COLON) begin
            r.n = 2'd1;
            r.mode = M_COLON;
          end else begin
            r.n = 2'd1;
            r.last = 3'b001;
            r.mode = M_BETWEEN;
          end
        end else begin
          r.n = 2'd1;
        end
      end
      M_QUOTEN: begin
        r.n = 2'd1;
        if (f == CH_QUOTE) begin
          r.last = 3'b001;
          r.mode = M_BETWEEN;
        end
      end
      M_COMMENT: begin
        r.n = 2'd0;
      end
      default: begin
        r.mode = M_BETWEEN;
      end
    endcase
    if (id_byte) begin
      if (stall) begin
        r.stop = 1'b1;
      end else begin
        cont = is_ident(nb);
        col = colon_ok && nb == CH_COLON;
        r.n = 2'd1;
        r.first = {2'b00, id_first};
        r.last = {2'b00, !cont && !col};
        if (cont) r.mode = colon_ok ? M_IDC : M_IDN;
        else if (col) r.mode = M_COLON;
        else r.mode = M_BETWEEN;
      end
    end
    if (r.stop) begin
      r.n = 2'd0;
      r.adv = 2'd0;
      r.mode = mode;
    end
    lex_step = r;
  endfunction

endpackage

// File: sv/ir_text_tokenizer.sv
// ir_text_tokenizer: lexes IR source text, one byte per input transfer
// results are registered in the result slots from the input register; token bytes trail
//   the input by at most two bytes of lookahead
// throughput: one byte per cycle while out_ready is high and each byte gives at most one
//   result; a byte with more (up to 5) holds input while the one-wide port drains them
// reset: synchronous, clears lexer mode, lookahead count, error hold and line count to one
`timescale 1ns / 1ps
`include "ir_text_tokenizer_macros.svh"

module ir_text_tokenizer #(
  parameter int LINE_WIDTH = irtt_pkg::LINE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    char_in,
  input  logic                          text_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    char_out,
  output logic                          tok_first,
  output logic                          tok_last,
  output logic [irtt_pkg::LINE_NO_W-1:0] line_no,
  output logic [1:0]                    err_code,
  output logic                          text_done,
  output logic                          run_last
);
  import irtt_pkg::*;

  // input register
  logic       inq_valid;
  logic [7:0] inq_char;
  logic       inq_end;

  // lexer state
  logic [HOLD-1:0][7:0]  ahead_buf, ahead_buf_next;
  logic [1:0]            ahead_count, ahead_count_next;
  lex_mode_t             lex_mode, lex_mode_next;
  logic [LINE_WIDTH-1:0] line_count, line_count_next;
  logic                  err_hold, err_hold_next;

  // result group, drained from slot 0
  res_t [MAX_RES-1:0] slot;
  logic [CNT_W-1:0]   grp_cnt;

  logic fire;
  logic pop;
  logic grp_free;

  logic [WIN-1:0][7:0]       w;
  logic [WIN_W-1:0]          len;
  logic [WIN_W-1:0]          p;
  logic [WIN_W-1:0]          q1;
  logic [WIN_W-1:0]          q2;
  logic [WIN_W-1:0]          qh;
  logic                      h1;
  logic                      h2;
  logic [7:0]                b0;
  logic [7:0]                b1;
  logic [7:0]                b2;
  lex_mode_t                 mode;
  logic                      going;
  logic                      sig_err;
  logic                      done;
  logic [WIN_W-1:0]          nls;
  logic [CNT_W-1:0]          res_cnt;
  logic [CNT_W-1:0]          res_top;
  lex_step_t                 st;
  res_t [MAX_RES-1:0]        res;
  logic [WIN:0][LINE_WIDTH-1:0] line_inc;
  logic [LINE_WIDTH:0]       line_sum;

  assign out_valid = grp_cnt != '0;
  assign pop       = out_valid && out_ready;
  assign grp_free  = (grp_cnt == '0) || (grp_cnt == CNT_W'(1) && out_ready);
  assign fire      = inq_valid && grp_free;
  assign in_ready  = !inq_valid || fire;

  assign char_out  = slot[0].ch;
  assign tok_first = slot[0].first;
  assign tok_last  = slot[0].last;
  assign line_no   = slot[0].line;
  assign err_code  = slot[0].err;
  assign text_done = slot[0].done;
  assign run_last  = slot[0].run_last;

  // line count plus each possible number of newlines, saturating
  always_comb begin
    line_sum = '0;
    for (int j = 0; j <= WIN; j++) begin
      line_sum = {1'b0, line_count} + (LINE_WIDTH + 1)'(j);
      line_inc[j] = line_sum[LINE_WIDTH] ? '1 : line_sum[LINE_WIDTH-1:0];
    end
  end

  always_comb begin
    w = {WIN{CH_NL}};
    case (ahead_count)
      2'd0: begin
        w[0] = inq_char;
      end
      2'd1: begin
        w[0] = ahead_buf[0];
        w[1] = inq_char;
      end
      default: begin
        w[0] = ahead_buf[0];
        w[1] = ahead_buf[1];
        w[2] = inq_char;
      end
    endcase
    // a text not closed by newline gets one
    len = WIN_W'(ahead_count) + WIN_W'(1) + WIN_W'(inq_end && inq_char != CH_NL);

    res = '0;
    res_cnt = '0;
    res_top = '0;
    p = '0;
    q1 = '0;
    q2 = '0;
    qh = '0;
    h1 = 1'b0;
    h2 = 1'b0;
    b0 = '0;
    b1 = '0;
    b2 = '0;
    st = '0;
    nls = '0;
    mode = lex_mode;
    going = !err_hold;
    sig_err = 1'b0;
    done = 1'b0;

    for (int s = 0; s < WIN; s++) begin
      if (going && p < len) begin
        q1 = p + WIN_W'(1);
        q2 = p + WIN_W'(2);
        h1 = q1 < len;
        h2 = q2 < len;
        b0 = w[p[1:0]];
        b1 = h1 ? w[q1[1:0]] : '0;
        b2 = h2 ? w[q2[1:0]] : '0;
        st = lex_step(mode, b0, h1, b1, h2, b2, inq_end);
        if (st.stop) begin
          going = 1'b0;
        end else if (st.sig_err) begin
          if (res_cnt < CNT_W'(MAX_RES)) begin
            res[res_cnt].line = LINE_NO_W'(line_inc[nls]);
            res[res_cnt].err = ERR_IDENT;
          end
          res_cnt = res_cnt + CNT_W'(1);
          going = 1'b0;
          sig_err = 1'b1;
        end else begin
          for (int j = 0; j < 3; j++) begin
            if (2'(j) < st.n && res_cnt < CNT_W'(MAX_RES)) begin
              res[res_cnt].ch = st.ch[j];
              res[res_cnt].first = st.first[j];
              res[res_cnt].last = st.last[j];
              res[res_cnt].line = LINE_NO_W'(line_inc[nls]);
              res[res_cnt].err = ERR_NONE;
              res_cnt = res_cnt + CNT_W'(1);
            end
          end
          // newline token carries the line it ends
          nls = nls + WIN_W'(st.nl);
          mode = st.mode;
          p = p + WIN_W'(st.adv);
        end
      end
    end

    ahead_buf_next = ahead_buf;
    ahead_count_next = '0;
    lex_mode_next = mode;
    line_count_next = line_inc[nls];
    err_hold_next = err_hold;

    if (err_hold) begin
      if (inq_end) begin
        lex_mode_next = M_BETWEEN;
        line_count_next = LINE_WIDTH'(1);
        err_hold_next = 1'b0;
      end
    end else if (sig_err) begin
      done = 1'b1;
      lex_mode_next = M_BETWEEN;
      if (inq_end) line_count_next = LINE_WIDTH'(1);
      else err_hold_next = 1'b1;
    end else if (inq_end) begin
      if ((mode == M_QUOTEC || mode == M_QUOTEN) && res_cnt < CNT_W'(MAX_RES)) begin
        res[res_cnt].line = LINE_NO_W'(line_inc[nls]);
        res[res_cnt].err = ERR_QUOTE;
        res_cnt = res_cnt + CNT_W'(1);
      end
      done = 1'b1;
      lex_mode_next = M_BETWEEN;
      line_count_next = LINE_WIDTH'(1);
    end else begin
      // keep the undecided tail of the window
      ahead_count_next = 2'(len - p);
      for (int i = 0; i < HOLD; i++) begin
        qh = p + WIN_W'(i);
        if (qh < len) ahead_buf_next[i] = w[qh[1:0]];
      end
    end

    if (res_cnt != '0) begin
      res_top = res_cnt - CNT_W'(1);
      res[res_top].run_last = 1'b1;
      res[res_top].done = done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
      ahead_count <= '0;
      lex_mode <= M_BETWEEN;
      line_count <= LINE_WIDTH'(1);
      err_hold <= 1'b0;
      grp_cnt <= '0;
    end else begin
      if (in_valid && in_ready) inq_valid <= 1'b1;
      else if (fire) inq_valid <= 1'b0;
      if (fire) begin
        ahead_count <= ahead_count_next;
        lex_mode <= lex_mode_next;
        line_count <= line_count_next;
        err_hold <= err_hold_next;
      end
      if (fire && res_cnt != '0) grp_cnt <= res_cnt;
      else if (pop) grp_cnt <= grp_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_char <= char_in;
      inq_end <= text_end;
    end
    if (fire) ahead_buf <= ahead_buf_next;
    if (fire && res_cnt != '0) begin
      slot <= res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) slot[i] <= slot[i + 1];
    end
  end

  `IRTT_ASSERT_NOW(a_run_last_tail, out_valid, run_last == (grp_cnt == CNT_W'(1)), "run_last not on group tail")
  `IRTT_ASSERT_NOW(a_hold_silent, fire && err_hold, res_cnt == '0, "result while dropping after error")
  `IRTT_ASSERT_NOW(a_end_result, fire && inq_end && !err_hold, res_cnt != '0, "text end without result")
  `IRTT_ASSERT_NEXT(a_end_clears, fire && inq_end, lex_mode == M_BETWEEN && ahead_count == '0 && !err_hold, "state not cleared after text end")

endmodule
